// ===== rtl/core/i2c_bus_clear_sequencer_unit_defines.svh =====
// Assertion macros shared by the bus-clear sequencer RTL.
`ifndef I2C_BUS_CLEAR_SEQUENCER_UNIT_DEFINES_SVH
`define I2C_BUS_CLEAR_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define I2CBC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, held off during reset.
`define I2CBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/i2cbc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package i2cbc_pkg;

	localparam int unsigned DelayW = 8;
	localparam int unsigned PulseW = 4;
	localparam int unsigned ToggleW = PulseW + 1;
	localparam int unsigned StatusW = 2;
	localparam int unsigned CfgIdxW = 2;

	localparam logic [DelayW-1:0] FULL_DELAY_RST = 8'd5;
	localparam logic [DelayW-1:0] SHORT_DELAY_RST = 8'd2;
	localparam logic [PulseW-1:0] PULSE_COUNT_RST = 4'd9;

	localparam logic [CfgIdxW-1:0] REG_FULL_DELAY = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_SHORT_DELAY = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_PULSE_COUNT = 2'd2;

	localparam logic [StatusW-1:0] ST_FREED = 2'd0;
	localparam logic [StatusW-1:0] ST_STUCK = 2'd1;
	localparam logic [StatusW-1:0] ST_NOT_FREED = 2'd2;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_PRE_SCL = 3'd1,
		PH_PRE_SDA = 3'd2,
		PH_TOG_SCL = 3'd3,
		PH_TOG_SDA = 3'd4
	} phase_t;

	typedef struct packed {
		logic [DelayW-1:0] full_delay_ticks;
		logic [DelayW-1:0] short_delay_ticks;
		logic [PulseW-1:0] pulse_count;
	} cfg_t;

	typedef struct packed {
		logic operation;
		logic scl_level;
		logic sda_level;
	} item_t;

	typedef struct packed {
		phase_t phase;
		logic [DelayW-1:0] wait_count;
		logic [ToggleW-1:0] toggle_count;
		logic scl_state;
		logic sda_state;
		logic [StatusW-1:0] last_status;
	} seq_state_t;

	typedef struct packed {
		logic scl_drive;
		logic sda_drive;
		logic busy_res;
		logic done_res;
		logic [StatusW-1:0] status;
	} result_t;

	function automatic logic [DelayW-1:0] eff_delay(input logic [DelayW-1:0] d);
		return (d == '0) ? DelayW'(1) : d;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/i2cbc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface i2cbc_in_if;
	logic valid;
	logic ready;
	logic operation;
	logic scl_level;
	logic sda_level;

	modport source (output valid, output operation, output scl_level, output sda_level,
		input ready);
	modport sink (input valid, input operation, input scl_level, input sda_level,
		output ready);
endinterface

interface i2cbc_out_if;
	logic valid;
	logic ready;
	logic scl_drive;
	logic sda_drive;
	logic busy_res;
	logic done_res;
	logic [1:0] status;

	modport source (output valid, output scl_drive, output sda_drive, output busy_res,
		output done_res, output status, input ready);
	modport sink (input valid, input scl_drive, input sda_drive, input busy_res,
		input done_res, input status, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/i2c_bus_clear_sequencer_unit.sv =====
// I2C bus-clear sequencer: drives SCL/SDA through the recovery of pulse_count SCL pulses.
// tick channel: one word per time tick; operation 1 starts (or restarts) the
// sequence, 0 advances it one tick using the sampled scl_level and sda_level.
// result channel: exactly one word per tick word, in order, giving the SCL and
// SDA drive levels, busy_res, done_res (on the finishing tick) and the status
// of the last finished sequence (freed, SCL stuck low, not freed).
// Configuration: cfg_we/cfg_index/cfg_wdata write full_delay_ticks (0),
// short_delay_ticks (1) and pulse_count (2); write only while idle.
// A word accepted into the input register has its result computed from the
// sequencer state and written to the result register, which drives result.
// Throughput: one word per cycle while result.ready stays high, set by the
// single state update between the input register and the result register.
// When the receiver stalls, the result register holds, the input register
// holds and tick.ready drops once both are full; nothing is lost.
// Reset: delays 5 and 2, pulse_count 9, sequencer idle, both lines released
// high, status freed, both registers empty.
`timescale 1ns / 1ps
`default_nettype none
`include "i2c_bus_clear_sequencer_unit_defines.svh"
module i2c_bus_clear_sequencer_unit (
	input wire logic clk,
	input wire logic arst_n,
	i2cbc_in_if.sink tick,
	i2cbc_out_if.source result,
	input wire logic cfg_we,
	input wire logic [i2cbc_pkg::CfgIdxW-1:0] cfg_index,
	input wire logic [i2cbc_pkg::DelayW-1:0] cfg_wdata
);

	i2cbc_pkg::cfg_t cfg;
	i2cbc_pkg::item_t item_s1;
	logic vld_s1;
	i2cbc_pkg::seq_state_t state_q;
	i2cbc_pkg::seq_state_t state_nxt;
	i2cbc_pkg::result_t res_nxt;
	i2cbc_pkg::result_t res_q;
	logic res_vld_q;
	logic proc_en;
	logic take_in;

	i2cbc_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.cfg(cfg)
	);

	i2cbc_step u_step (
		.cfg(cfg),
		.item(item_s1),
		.cur(state_q),
		.nxt(state_nxt),
		.res(res_nxt)
	);

	assign proc_en = vld_s1 & (~res_vld_q | result.ready);
	assign tick.ready = ~vld_s1 | proc_en;
	assign take_in = tick.valid & tick.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (tick.ready) begin
			vld_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1.operation <= tick.operation;
			item_s1.scl_level <= tick.scl_level;
			item_s1.sda_level <= tick.sda_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase <= i2cbc_pkg::PH_IDLE;
			state_q.wait_count <= '0;
			state_q.toggle_count <= '0;
			state_q.scl_state <= 1'b1;
			state_q.sda_state <= 1'b1;
			state_q.last_status <= i2cbc_pkg::ST_FREED;
		end else if (proc_en) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (proc_en) begin
			res_vld_q <= 1'b1;
		end else if (result.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc_en) begin
			res_q <= res_nxt;
		end
	end

	assign result.valid = res_vld_q;
	assign result.scl_drive = res_q.scl_drive;
	assign result.sda_drive = res_q.sda_drive;
	assign result.busy_res = res_q.busy_res;
	assign result.done_res = res_q.done_res;
	assign result.status = res_q.status;

	`I2CBC_ASSERT_SAME(a_busy_wait_nonzero, clk, arst_n,
		state_q.phase != i2cbc_pkg::PH_IDLE, state_q.wait_count != '0,
		"running sequencer with empty wait counter")
	`I2CBC_ASSERT_NEXT(a_start_loads, clk, arst_n, proc_en && item_s1.operation,
		state_q.phase == i2cbc_pkg::PH_PRE_SCL && state_q.scl_state,
		"start word did not enter the first wait with SCL released")
	`I2CBC_ASSERT_NEXT(a_done_idle, clk, arst_n, proc_en && res_nxt.done_res,
		res_vld_q && !res_q.busy_res && state_q.phase == i2cbc_pkg::PH_IDLE,
		"finished sequence left the sequencer running")

endmodule
`default_nettype wire

// ===== rtl/core/i2cbc_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
module i2cbc_cfg_regs (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [i2cbc_pkg::CfgIdxW-1:0] cfg_index,
	input wire logic [i2cbc_pkg::DelayW-1:0] cfg_wdata,
	output i2cbc_pkg::cfg_t cfg
);

	i2cbc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.full_delay_ticks <= i2cbc_pkg::FULL_DELAY_RST;
			cfg_q.short_delay_ticks <= i2cbc_pkg::SHORT_DELAY_RST;
			cfg_q.pulse_count <= i2cbc_pkg::PULSE_COUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				i2cbc_pkg::REG_FULL_DELAY: begin
					cfg_q.full_delay_ticks <= cfg_wdata;
				end
				i2cbc_pkg::REG_SHORT_DELAY: begin
					cfg_q.short_delay_ticks <= cfg_wdata;
				end
				i2cbc_pkg::REG_PULSE_COUNT: begin
					cfg_q.pulse_count <= cfg_wdata[i2cbc_pkg::PulseW-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ===== rtl/core/i2cbc_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
module i2cbc_step (
	input wire i2cbc_pkg::cfg_t cfg,
	input wire i2cbc_pkg::item_t item,
	input wire i2cbc_pkg::seq_state_t cur,
	output i2cbc_pkg::seq_state_t nxt,
	output i2cbc_pkg::result_t res
);

	logic [i2cbc_pkg::PulseW-1:0] pulses;
	logic [i2cbc_pkg::ToggleW-1:0] limit;
	logic [i2cbc_pkg::DelayW-1:0] wait_dec;
	logic [i2cbc_pkg::ToggleW-1:0] tog_inc;
	logic tgl_stuck;
	logic tgl_scl;
	logic [i2cbc_pkg::DelayW-1:0] tgl_wait;
	logic done;

	always_comb begin
		pulses = (cfg.pulse_count == '0) ? i2cbc_pkg::PulseW'(1) : cfg.pulse_count;
		limit = {pulses, 1'b0};
		wait_dec = cur.wait_count - i2cbc_pkg::DelayW'(1);
		tog_inc = cur.toggle_count + i2cbc_pkg::ToggleW'(1);
		tgl_stuck = cur.scl_state & ~item.scl_level;
		tgl_scl = ~cur.scl_state;
		tgl_wait = i2cbc_pkg::eff_delay(tgl_scl ? cfg.full_delay_ticks
			: cfg.short_delay_ticks);
	end

	always_comb begin
		nxt = cur;
		done = 1'b0;
		if (item.operation) begin
			nxt.scl_state = 1'b1;
			nxt.toggle_count = '0;
			nxt.wait_count = i2cbc_pkg::eff_delay(cfg.full_delay_ticks);
			nxt.phase = i2cbc_pkg::PH_PRE_SCL;
		end else if (cur.phase != i2cbc_pkg::PH_IDLE) begin
			nxt.wait_count = wait_dec;
			if (wait_dec == '0) begin
				unique case (cur.phase)
					i2cbc_pkg::PH_PRE_SCL: begin
						nxt.sda_state = 1'b1;
						nxt.wait_count = i2cbc_pkg::eff_delay(cfg.short_delay_ticks);
						nxt.phase = i2cbc_pkg::PH_PRE_SDA;
					end
					i2cbc_pkg::PH_PRE_SDA: begin
						if (tgl_stuck) begin
							nxt.last_status = i2cbc_pkg::ST_STUCK;
							nxt.phase = i2cbc_pkg::PH_IDLE;
							nxt.wait_count = '0;
							done = 1'b1;
						end else begin
							nxt.scl_state = tgl_scl;
							nxt.wait_count = tgl_wait;
							nxt.phase = i2cbc_pkg::PH_TOG_SCL;
						end
					end
					i2cbc_pkg::PH_TOG_SCL: begin
						nxt.sda_state = cur.scl_state;
						nxt.wait_count = i2cbc_pkg::eff_delay(cfg.short_delay_ticks);
						nxt.phase = i2cbc_pkg::PH_TOG_SDA;
					end
					i2cbc_pkg::PH_TOG_SDA: begin
						nxt.toggle_count = tog_inc;
						if (cur.scl_state && item.scl_level && item.sda_level) begin
							nxt.last_status = i2cbc_pkg::ST_FREED;
							nxt.phase = i2cbc_pkg::PH_IDLE;
							nxt.wait_count = '0;
							done = 1'b1;
						end else if (tog_inc >= limit) begin
							nxt.last_status = i2cbc_pkg::ST_NOT_FREED;
							nxt.phase = i2cbc_pkg::PH_IDLE;
							nxt.wait_count = '0;
							done = 1'b1;
						end else if (tgl_stuck) begin
							nxt.last_status = i2cbc_pkg::ST_STUCK;
							nxt.phase = i2cbc_pkg::PH_IDLE;
							nxt.wait_count = '0;
							done = 1'b1;
						end else begin
							nxt.scl_state = tgl_scl;
							nxt.wait_count = tgl_wait;
							nxt.phase = i2cbc_pkg::PH_TOG_SCL;
						end
					end
					default: begin
						nxt.phase = i2cbc_pkg::PH_IDLE;
						nxt.wait_count = '0;
					end
				endcase
			end
		end
	end

	always_comb begin
		res.scl_drive = nxt.scl_state;
		res.sda_drive = nxt.sda_state;
		res.busy_res = (nxt.phase != i2cbc_pkg::PH_IDLE);
		res.done_res = done;
		res.status = nxt.last_status;
	end

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
	import i2cbc_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned HOLD_CYCLES = 300;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CfgIdxW-1:0] cfg_index;
	logic [DelayW-1:0] cfg_wdata;

	i2cbc_in_if tick_if();
	i2cbc_out_if res_if();

	i2c_bus_clear_sequencer_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.tick(tick_if),
		.result(res_if),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	item_t tick_queue[$];
	result_t predicted_words[$];

	int send_idle_pct;
	int recv_stall_pct;
	int stall_kick;
	int stall_seen;
	int stall_left;
	int mismatch_count;
	int fail_count;
	int cycle_count;
	bit in_fire;

	// sequencer copy
	phase_t sq_phase;
	logic [DelayW-1:0] sq_wait;
	logic [ToggleW-1:0] sq_toggles;
	logic sq_scl;
	logic sq_sda;
	logic [StatusW-1:0] sq_status;
	logic sq_done;
	logic [DelayW-1:0] cfg_full_ticks;
	logic [DelayW-1:0] cfg_short_ticks;
	logic [PulseW-1:0] cfg_pulses;

	function automatic logic [DelayW-1:0] at_least_one(input logic [DelayW-1:0] d);
		return (d == '0) ? DelayW'(1) : d;
	endfunction

	function automatic void close_sequence(input logic [StatusW-1:0] code);
		sq_status = code;
		sq_phase = PH_IDLE;
		sq_wait = '0;
		sq_done = 1'b1;
	endfunction

	function automatic void toggle_scl(input logic scl_in);
		if (sq_scl && !scl_in) begin
			close_sequence(ST_STUCK);
		end else begin
			sq_scl = ~sq_scl;
			sq_wait = at_least_one(sq_scl ? cfg_full_ticks : cfg_short_ticks);
			sq_phase = PH_TOG_SCL;
		end
	endfunction

	function automatic result_t step_sequencer(input item_t w);
		result_t r;
		int pulses;
		pulses = (cfg_pulses == '0) ? 1 : int'(cfg_pulses);
		sq_done = 1'b0;
		if (w.operation) begin
			sq_scl = 1'b1;
			sq_toggles = '0;
			sq_wait = at_least_one(cfg_full_ticks);
			sq_phase = PH_PRE_SCL;
		end else if (sq_phase != PH_IDLE) begin
			sq_wait = sq_wait - DelayW'(1);
			if (sq_wait == '0) begin
				case (sq_phase)
					PH_PRE_SCL: begin
						sq_sda = 1'b1;
						sq_wait = at_least_one(cfg_short_ticks);
						sq_phase = PH_PRE_SDA;
					end
					PH_PRE_SDA: begin
						toggle_scl(w.scl_level);
					end
					PH_TOG_SCL: begin
						sq_sda = sq_scl;
						sq_wait = at_least_one(cfg_short_ticks);
						sq_phase = PH_TOG_SDA;
					end
					PH_TOG_SDA: begin
						sq_toggles = sq_toggles + ToggleW'(1);
						if (sq_scl && w.scl_level && w.sda_level) begin
							close_sequence(ST_FREED);
						end else if (int'(sq_toggles) >= 2 * pulses) begin
							close_sequence(ST_NOT_FREED);
						end else begin
							toggle_scl(w.scl_level);
						end
					end
					default: begin
						sq_phase = PH_IDLE;
						sq_wait = '0;
					end
				endcase
			end
		end
		r.scl_drive = sq_scl;
		r.sda_drive = sq_sda;
		r.busy_res = (sq_phase != PH_IDLE);
		r.done_res = sq_done;
		r.status = sq_status;
		return r;
	endfunction

	task automatic push_word(input logic op, input logic scl, input logic sda);
		tick_queue.push_back({op, scl, sda});
	endtask

	task automatic wait_drained();
		while (tick_queue.size() != 0 || predicted_words.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DelayW-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_FULL_DELAY: cfg_full_ticks = val;
			REG_SHORT_DELAY: cfg_short_ticks = val;
			REG_PULSE_COUNT: cfg_pulses = val[PulseW-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(input int full, input int short_t, input int pulses);
		write_reg(REG_FULL_DELAY, full[DelayW-1:0]);
		write_reg(REG_SHORT_DELAY, short_t[DelayW-1:0]);
		write_reg(REG_PULSE_COUNT, {4'd0, pulses[PulseW-1:0]});
	endtask

	// drain, then clock the sequence out with both lines high
	task automatic settle();
		wait_drained();
		while (sq_phase != PH_IDLE) begin
			repeat (32) push_word(1'b0, 1'b1, 1'b1);
			wait_drained();
		end
	endtask

	task automatic add_traffic(input int budget);
		int count;
		int n;
		int est;
		int f;
		int s;
		int p;
		int scl_low_pct;
		int sda_high_pct;
		count = 0;
		while (count < budget) begin
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 3))
					push_word(1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end else begin
				f = int'(at_least_one(cfg_full_ticks));
				s = int'(at_least_one(cfg_short_ticks));
				p = (cfg_pulses == '0) ? 1 : int'(cfg_pulses);
				est = f + s + 2 * p * ((f > s ? f : s) + s) + 4;
				n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, est) : est;
				case ($urandom_range(0, 2))
					0: scl_low_pct = 0;
					1: scl_low_pct = 2;
					default: scl_low_pct = 15;
				endcase
				case ($urandom_range(0, 3))
					0: sda_high_pct = 0;
					1: sda_high_pct = 30;
					2: sda_high_pct = 70;
					default: sda_high_pct = 100;
				endcase
				push_word(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				repeat (n)
					push_word(1'b0, $urandom_range(0, 99) >= scl_low_pct,
						$urandom_range(0, 99) < sda_high_pct);
				count += n + 1;
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("i2c_bus_clear_sequencer_unit test failed");
			$finish;
		end
	end

	// driver: hold the word until taken
	always @(negedge clk) begin
		if (arst_n) begin
			if (!(tick_if.valid && !in_fire)) begin
				if (tick_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					tick_if.valid <= 1'b1;
					tick_if.operation <= tick_queue[0].operation;
					tick_if.scl_level <= tick_queue[0].scl_level;
					tick_if.sda_level <= tick_queue[0].sda_level;
				end else begin
					tick_if.valid <= 1'b0;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else if (stall_kick != stall_seen) begin
			stall_seen <= stall_kick;
			stall_left <= HOLD_CYCLES;
			res_if.ready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			res_if.ready <= 1'b0;
		end else begin
			res_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin : monitor
		result_t want;
		if (arst_n) begin
			if (res_if.valid && res_if.ready) begin
				if (predicted_words.size() == 0) begin
					fail_count++;
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result word: scl %0b sda %0b ",
							"busy %0b done %0b st %0d",
							res_if.scl_drive, res_if.sda_drive, res_if.busy_res,
							res_if.done_res, res_if.status);
				end else begin
					want = predicted_words.pop_front();
					if (res_if.scl_drive !== want.scl_drive || res_if.sda_drive !== want.sda_drive
						|| res_if.busy_res !== want.busy_res
						|| res_if.done_res !== want.done_res
						|| res_if.status !== want.status) begin
						fail_count++;
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("mismatch exp scl %0b sda %0b busy %0b done %0b st %0d, ",
								want.scl_drive, want.sda_drive, want.busy_res,
								want.done_res, want.status,
								"got scl %0b sda %0b busy %0b done %0b st %0d",
								res_if.scl_drive, res_if.sda_drive, res_if.busy_res,
								res_if.done_res, res_if.status);
					end
				end
			end
			in_fire = tick_if.valid && tick_if.ready;
			if (in_fire)
				predicted_words.push_back(step_sequencer(tick_queue.pop_front()));
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_FULL_DELAY;
		cfg_wdata = '0;
		tick_if.valid = 1'b0;
		tick_if.operation = 1'b0;
		tick_if.scl_level = 1'b0;
		tick_if.sda_level = 1'b0;
		res_if.ready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		stall_kick = 0;
		stall_seen = 0;
		stall_left = 0;
		mismatch_count = 0;
		fail_count = 0;
		cycle_count = 0;
		in_fire = 1'b0;
		sq_phase = PH_IDLE;
		sq_wait = '0;
		sq_toggles = '0;
		sq_scl = 1'b1;
		sq_sda = 1'b1;
		sq_status = ST_FREED;
		sq_done = 1'b0;
		cfg_full_ticks = FULL_DELAY_RST;
		cfg_short_ticks = SHORT_DELAY_RST;
		cfg_pulses = PULSE_COUNT_RST;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// ticks while idle, then start, restart and SCL stuck low
		push_word(1'b0, 1'b0, 1'b0);
		push_word(1'b0, 1'b0, 1'b1);
		push_word(1'b0, 1'b1, 1'b0);
		push_word(1'b0, 1'b1, 1'b1);
		push_word(1'b1, 1'b0, 1'b0);
		repeat (3) push_word(1'b0, 1'b1, 1'b1);
		push_word(1'b1, 1'b1, 1'b1);
		repeat (6) push_word(1'b0, 1'b1, 1'b0);
		push_word(1'b0, 1'b0, 1'b1);
		push_word(1'b0, 1'b1, 1'b1);
		settle();

		set_config(1, 1, 1);
		send_idle_pct = 45;
		add_traffic(60);
		settle();

		set_config(0, 0, 0);
		send_idle_pct = 0;
		recv_stall_pct = 45;
		add_traffic(50);
		settle();

		set_config($urandom_range(1, 4), $urandom_range(1, 3), $urandom_range(1, 15));
		send_idle_pct = 31;
		recv_stall_pct = 31;
		add_traffic(60);
		@(posedge clk);
		stall_kick++;
		wait_drained();
		add_traffic(30);
		settle();

		set_config(2, 1, 15);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		add_traffic(60);
		settle();

		set_config(255, 1, 15);
		send_idle_pct = 31;
		recv_stall_pct = 31;
		push_word(1'b1, 1'b1, 1'b0);
		repeat (260) push_word(1'b0, 1'b0, 1'($urandom_range(0, 1)));
		settle();

		set_config($urandom_range(1, 4), $urandom_range(1, 3), $urandom_range(1, 15));
		send_idle_pct = 45;
		recv_stall_pct = 0;
		add_traffic(50);
		settle();

		set_config(5, 2, 9);
		send_idle_pct = 0;
		recv_stall_pct = 45;
		add_traffic(50);
		settle();

		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("i2c_bus_clear_sequencer_unit test passed");
		else
			$display("i2c_bus_clear_sequencer_unit test failed");
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/i2cbc_pkg.sv
rtl/core/i2cbc_if.sv
rtl/core/i2cbc_cfg_regs.sv
rtl/core/i2cbc_step.sv
rtl/core/i2c_bus_clear_sequencer_unit.sv
test/tb_top.sv
